// File: rtl/gmm_pkg.sv
// Shared constants, types and coefficient tables of the multipath monitor.
package gmm_pkg;

    localparam int NUM_SATS   = 256;
    localparam int COUNT_BITS = 16;
    localparam int SAT_AW     = $clog2(NUM_SATS);
    localparam int SAT_EXT_W  = 11;

    localparam int SAT_W     = 8;
    localparam int SYS_W     = 3;
    localparam int RANGE_W   = 36;
    localparam int PHASE_W   = 48;
    localparam int OUT_W     = 32;
    localparam int WIDE_W    = 56;
    localparam int HALF_W    = 28;
    localparam int OPND_W    = HALF_W + 1;
    localparam int COEF_W    = 24;
    localparam int PROD_W    = OPND_W + COEF_W + 1;
    localparam int ACC_W     = 80;
    localparam int MAG_W     = OUT_W + 1;
    localparam int NP1_W     = COUNT_BITS + 1;
    localparam int ENTRY_W   = COUNT_BITS + 4 * OUT_W;
    localparam int STEP_W    = 4;
    localparam int STEP_LAST = 14;

    localparam logic [SYS_W-1:0] SYS_GPS     = 3'd0;
    localparam logic [SYS_W-1:0] SYS_GLONASS = 3'd1;
    localparam logic [SYS_W-1:0] SYS_GALILEO = 3'd2;
    localparam logic [SYS_W-1:0] SYS_BEIDOU  = 3'd3;

    localparam logic [COEF_W-1:0] A_STEP = 24'd65536;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_CALC     = 6'b000010,
        S_DIV_GO   = 6'b000100,
        S_DIV_WAIT = 6'b001000,
        S_WRITE    = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_LOADR1, ACC_LOADR2
    } t_acc_op;

    typedef enum logic [2:0] {
        CAP_NONE, CAP_D1, CAP_D2, CAP_M1, CAP_M2
    } t_cap;

    typedef enum logic [1:0] {
        OPND_PH1, OPND_PH2, OPND_D1, OPND_D2
    } t_opnd;

    typedef enum logic [2:0] {
        COEF_LAM1, COEF_LAM2, COEF_A, COEF_A1, COEF_A2
    } t_coef;

    typedef struct packed {
        logic    in_load;
        t_opnd   opnd;
        logic    hi;
        t_coef   coef;
        t_acc_op acc_op;
        t_cap    cap;
        logic    div_start;
        logic    div_sel;
        logic    wr_en;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic first;
        logic div_done;
    } t_dp_stat;

    function automatic logic [COEF_W-1:0] lam1_of(input logic [SYS_W-1:0] sys);
        logic [COEF_W-1:0] v;
        case (sys)
            SYS_BEIDOU: v = 24'd12585500;
            default:    v = 24'd12471086;
        endcase
        return v;
    endfunction

    function automatic logic [COEF_W-1:0] lam2_of(input logic [SYS_W-1:0] sys);
        logic [COEF_W-1:0] v;
        case (sys)
            SYS_GALILEO: v = 24'd16275824;
            SYS_BEIDOU:  v = 24'd15488284;
            default:     v = 24'd16004561;
        endcase
        return v;
    endfunction

    function automatic logic [COEF_W-1:0] acoef_of(input logic [SYS_W-1:0] sys);
        logic [COEF_W-1:0] v;
        case (sys)
            SYS_GALILEO: v = 24'd186381;
            SYS_BEIDOU:  v = 24'd254762;
            default:     v = 24'd202602;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/gnss_multipath_monitor.sv
// Dual-frequency code-minus-carrier multipath monitor, top level.
//
// Input channel i_valid/o_ready carries one observation per transaction; the
// output channel o_valid/i_ready returns exactly one result per observation,
// in order. A skipped observation (GLONASS or any zero range or phase) gives
// accepted = 0, zero combination and running fields, and leaves state alone.
// A skipped observation goes straight from the first calculation step to the
// output; otherwise the shared 29x25 multiplier forms both phase distances and
// both combinations, which is all on a satellite's first use. Later observations
// add two 33-bit divisions by n+1 on one restoring divider.
// The result is valid in the cycle after the observation's last cycle.
// One observation is worked at a time; o_ready is high only when the block
// is idle. A finished result waits in the output register while the next
// observation is taken and worked; if the receiver still stalls when that one
// is done, it is held and o_ready stays low until the output register frees.
// Reset clears the per-satellite valid bits, so every count reads zero; the
// state memory itself needs no clearing pass.
module gnss_multipath_monitor (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [gmm_pkg::SAT_W-1:0]          i_sat_index,
    input  logic [gmm_pkg::SYS_W-1:0]          i_constellation,
    input  logic [gmm_pkg::RANGE_W-1:0]        i_range_first,
    input  logic [gmm_pkg::RANGE_W-1:0]        i_range_second,
    input  logic signed [gmm_pkg::PHASE_W-1:0] i_phase_first,
    input  logic signed [gmm_pkg::PHASE_W-1:0] i_phase_second,
    input  logic                               i_epoch_end,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_accepted,
    output logic signed [gmm_pkg::OUT_W-1:0]   o_combo_first,
    output logic signed [gmm_pkg::OUT_W-1:0]   o_combo_second,
    output logic signed [gmm_pkg::OUT_W-1:0]   o_running_first,
    output logic signed [gmm_pkg::OUT_W-1:0]   o_running_second,
    output logic                               o_epoch_done
);
    import gmm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    gmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_ready (i_ready),
        .i_stat      (stat),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    gmm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_sat_index      (i_sat_index),
        .i_constellation  (i_constellation),
        .i_range_first    (i_range_first),
        .i_range_second   (i_range_second),
        .i_phase_first    (i_phase_first),
        .i_phase_second   (i_phase_second),
        .i_epoch_end      (i_epoch_end),
        .o_accepted       (o_accepted),
        .o_combo_first    (o_combo_first),
        .o_combo_second   (o_combo_second),
        .o_running_first  (o_running_first),
        .o_running_second (o_running_second),
        .o_epoch_done     (o_epoch_done)
    );
endmodule

// File: rtl/gmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/gmm_div.sv
// Restoring divider, one quotient bit per cycle, remainder-nonzero flag.
module gmm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [gmm_pkg::MAG_W-1:0] i_dividend,
    input  logic [gmm_pkg::NP1_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [gmm_pkg::MAG_W-1:0] o_quot,
    output logic                      o_rem_nz
);
    import gmm_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [MAG_W-1:0] r_quot, n_quot;
    logic [NP1_W:0]   r_rem, n_rem;
    logic [NP1_W-1:0] r_dvs, n_dvs;
    logic [NP1_W:0]   rem_sh;
    logic [NP1_W:0]   rem_diff;

    assign rem_sh   = {r_rem[NP1_W-1:0], r_quot[MAG_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quot = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!rem_diff[NP1_W]) begin
                n_rem  = rem_diff;
                n_quot = {r_quot[MAG_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_quot = {r_quot[MAG_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(MAG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_done   = r_done;
    assign o_quot   = r_quot;
    assign o_rem_nz = |r_rem;
endmodule

// File: rtl/gmm_ctrl.sv
// Controller: sequences the multiply steps, the two divisions, the write-back and output.
module gmm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  gmm_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output gmm_pkg::t_dp_cmd  o_cmd
);
    import gmm_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_pass, n_pass;
    logic              r_out_valid, n_out_valid;
    t_dp_cmd           cmd;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_pass      = r_pass;
        n_out_valid = r_out_valid;
        cmd         = '0;
        cmd.div_sel = r_pass;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.in_load = 1'b1;
                    n_step      = '0;
                    n_pass      = 1'b0;
                    n_state     = S_CALC;
                end
            end
            S_CALC: begin
                case (r_step)
                    4'd0: begin
                        cmd.opnd = OPND_PH1; cmd.coef = COEF_LAM1; cmd.acc_op = ACC_LOAD;
                    end
                    4'd1: begin
                        cmd.opnd = OPND_PH1; cmd.hi = 1'b1; cmd.coef = COEF_LAM1;
                        cmd.acc_op = ACC_ADD;
                    end
                    4'd2: begin
                        cmd.opnd = OPND_PH2; cmd.coef = COEF_LAM2; cmd.acc_op = ACC_LOAD;
                        cmd.cap = CAP_D1;
                    end
                    4'd3: begin
                        cmd.opnd = OPND_PH2; cmd.hi = 1'b1; cmd.coef = COEF_LAM2;
                        cmd.acc_op = ACC_ADD;
                    end
                    4'd4: begin
                        cmd.cap = CAP_D2;
                    end
                    4'd5: begin
                        cmd.opnd = OPND_D1; cmd.coef = COEF_A1; cmd.acc_op = ACC_LOADR1;
                    end
                    4'd6: begin
                        cmd.opnd = OPND_D1; cmd.hi = 1'b1; cmd.coef = COEF_A1;
                        cmd.acc_op = ACC_SUB;
                    end
                    4'd7: begin
                        cmd.opnd = OPND_D2; cmd.coef = COEF_A; cmd.acc_op = ACC_ADD;
                    end
                    4'd8: begin
                        cmd.opnd = OPND_D2; cmd.hi = 1'b1; cmd.coef = COEF_A;
                        cmd.acc_op = ACC_ADD;
                    end
                    4'd9: begin
                        cmd.opnd = OPND_D1; cmd.coef = COEF_A2; cmd.acc_op = ACC_LOADR2;
                        cmd.cap = CAP_M1;
                    end
                    4'd10: begin
                        cmd.opnd = OPND_D1; cmd.hi = 1'b1; cmd.coef = COEF_A2;
                        cmd.acc_op = ACC_SUB;
                    end
                    4'd11: begin
                        cmd.opnd = OPND_D2; cmd.coef = COEF_A1; cmd.acc_op = ACC_ADD;
                    end
                    4'd12: begin
                        cmd.opnd = OPND_D2; cmd.hi = 1'b1; cmd.coef = COEF_A1;
                        cmd.acc_op = ACC_ADD;
                    end
                    4'd13: begin
                        cmd.cap = CAP_M2;
                    end
                    default: begin
                    end
                endcase
                n_step = r_step + 1'b1;
                if (i_stat.skip) begin
                    n_state = S_DONE;
                end else if (r_step == STEP_W'(STEP_LAST)) begin
                    n_state = i_stat.first ? S_WRITE : S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                cmd.div_start = 1'b1;
                n_state       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    if (r_pass) begin
                        n_state = S_WRITE;
                    end else begin
                        n_pass  = 1'b1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_WRITE: begin
                cmd.wr_en = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
endmodule

// File: rtl/gmm_dp.sv
// Datapath: input and output registers, shared multiplier and accumulator,
// per-satellite state memory and running-value update.
module gmm_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gmm_pkg::t_dp_cmd                 i_cmd,
    output gmm_pkg::t_dp_stat                o_stat,
    input  logic [gmm_pkg::SAT_W-1:0]        i_sat_index,
    input  logic [gmm_pkg::SYS_W-1:0]        i_constellation,
    input  logic [gmm_pkg::RANGE_W-1:0]      i_range_first,
    input  logic [gmm_pkg::RANGE_W-1:0]      i_range_second,
    input  logic signed [gmm_pkg::PHASE_W-1:0] i_phase_first,
    input  logic signed [gmm_pkg::PHASE_W-1:0] i_phase_second,
    input  logic                             i_epoch_end,
    output logic                             o_accepted,
    output logic signed [gmm_pkg::OUT_W-1:0] o_combo_first,
    output logic signed [gmm_pkg::OUT_W-1:0] o_combo_second,
    output logic signed [gmm_pkg::OUT_W-1:0] o_running_first,
    output logic signed [gmm_pkg::OUT_W-1:0] o_running_second,
    output logic                             o_epoch_done
);
    import gmm_pkg::*;

    localparam logic signed [47:0] S32_MAX = 48'sd2147483647;
    localparam logic signed [47:0] S32_MIN = -48'sd2147483648;

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [47:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > S32_MAX) begin
            r = S32_MAX[OUT_W-1:0];
        end else if (v < S32_MIN) begin
            r = S32_MIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    // transaction registers
    logic [SAT_W-1:0]          r_sat;
    logic [SYS_W-1:0]          r_sys;
    logic [RANGE_W-1:0]        r_r1, r_r2;
    logic signed [PHASE_W-1:0] r_p1, r_p2;
    logic                      r_ee;

    logic signed [WIDE_W-1:0]  r_d1, r_d2;
    logic signed [OUT_W-1:0]   r_m1, r_m2;
    logic signed [OUT_W-1:0]   r_run1, r_run2;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PROD_W-1:0]  r_prod;
    t_acc_op                   r_p_acc;
    t_cap                      r_p_cap;
    logic                      r_p_hi;

    logic [NUM_SATS-1:0]       r_valid;
    logic                      r_vbit;

    logic [SAT_EXT_W-1:0]      in_sat_ext, sat_ext;
    logic [SAT_AW-1:0]         raddr, waddr;
    logic [ENTRY_W-1:0]        ram_q, ram_d;
    logic [COUNT_BITS-1:0]     n_cnt, cnt_new;
    logic                      skip;

    assign in_sat_ext = SAT_EXT_W'(i_sat_index);
    assign sat_ext    = SAT_EXT_W'(r_sat);
    assign raddr      = in_sat_ext[SAT_AW-1:0];
    assign waddr      = sat_ext[SAT_AW-1:0];

    assign skip = (r_sys == SYS_GLONASS) || (r_r1 == '0) || (r_r2 == '0)
               || (r_p1 == '0) || (r_p2 == '0) || (sat_ext >= SAT_EXT_W'(NUM_SATS));

    assign n_cnt   = r_vbit ? ram_q[ENTRY_W-1 -: COUNT_BITS] : '0;
    assign cnt_new = (n_cnt == {COUNT_BITS{1'b1}}) ? n_cnt : n_cnt + 1'b1;

    // multiplier operand and coefficient selection
    logic signed [WIDE_W-1:0] wide;
    logic signed [OPND_W-1:0] opnd;
    logic [COEF_W-1:0]        coef;
    logic signed [COEF_W:0]   coef_s;
    logic signed [PROD_W-1:0] prod;

    always_comb begin
        case (i_cmd.opnd)
            OPND_PH1: wide = WIDE_W'(r_p1);
            OPND_PH2: wide = WIDE_W'(r_p2);
            OPND_D1:  wide = r_d1;
            default:  wide = r_d2;
        endcase
        case (i_cmd.coef)
            COEF_LAM1: coef = lam1_of(r_sys);
            COEF_LAM2: coef = lam2_of(r_sys);
            COEF_A:    coef = acoef_of(r_sys);
            COEF_A1:   coef = acoef_of(r_sys) + A_STEP;
            default:   coef = acoef_of(r_sys) + (A_STEP << 1);
        endcase
    end

    assign opnd   = i_cmd.hi ? $signed({wide[WIDE_W-1], wide[WIDE_W-1 -: HALF_W]})
                             : $signed({1'b0, wide[HALF_W-1:0]});
    assign coef_s = $signed({1'b0, coef});
    assign prod   = PROD_W'(opnd * coef_s);

    // accumulator
    logic signed [ACC_W-1:0] addend, rterm1, rterm2, acc_r16, acc_r32;
    logic signed [ACC_W-1:0] n_acc;

    assign addend  = r_p_hi ? (ACC_W'(r_prod) <<< HALF_W) : ACC_W'(r_prod);
    assign rterm1  = $signed(ACC_W'({r_r1, 32'b0}));
    assign rterm2  = $signed(ACC_W'({r_r2, 32'b0}));
    assign acc_r16 = r_acc + (ACC_W'(1) << 15);
    assign acc_r32 = r_acc + (ACC_W'(1) << 31);

    always_comb begin
        case (r_p_acc)
            ACC_LOAD:   n_acc = addend;
            ACC_ADD:    n_acc = r_acc + addend;
            ACC_SUB:    n_acc = r_acc - addend;
            ACC_LOADR1: n_acc = rterm1 - addend;
            ACC_LOADR2: n_acc = rterm2 - addend;
            default:    n_acc = r_acc;
        endcase
    end

    // running-value update through the shared divider
    logic signed [OUT_W-1:0] m_sel, last_sel, old_sel;
    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]        mag, quot, qm;
    logic [NP1_W-1:0]        np1;
    logic                    div_done, rem_nz;
    logic signed [OUT_W+2:0] run_sum;
    logic signed [OUT_W-1:0] run_new;

    assign m_sel    = i_cmd.div_sel ? r_m2 : r_m1;
    assign last_sel = i_cmd.div_sel ? $signed(ram_q[OUT_W-1:0])
                                    : $signed(ram_q[2*OUT_W-1 -: OUT_W]);
    assign old_sel  = i_cmd.div_sel ? $signed(ram_q[3*OUT_W-1 -: OUT_W])
                                    : $signed(ram_q[4*OUT_W-1 -: OUT_W]);
    assign diff     = MAG_W'(m_sel) - MAG_W'(last_sel);
    assign mag      = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    assign np1      = NP1_W'(n_cnt) + 1'b1;
    assign qm       = mag - quot - MAG_W'(rem_nz);
    assign run_sum  = diff[MAG_W-1] ? ((OUT_W+3)'(old_sel) - $signed((OUT_W+3)'(qm)))
                                    : ((OUT_W+3)'(old_sel) + $signed((OUT_W+3)'(qm)));
    assign run_new  = sat32(48'(run_sum));

    gmm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (mag),
        .i_divisor  (np1),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem_nz   (rem_nz)
    );

    logic signed [OUT_W-1:0] run1_v, run2_v;
    assign run1_v = (n_cnt == '0) ? '0 : r_run1;
    assign run2_v = (n_cnt == '0) ? '0 : r_run2;
    assign ram_d  = {cnt_new, run1_v, run2_v, r_m1, r_m2};

    gmm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SATS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (waddr),
        .i_wdata (ram_d),
        .i_re    (i_cmd.in_load),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_acc <= ACC_NONE;
            r_p_cap <= CAP_NONE;
            r_valid <= '0;
        end else begin
            r_p_acc <= i_cmd.acc_op;
            r_p_cap <= i_cmd.cap;
            if (i_cmd.wr_en) begin
                r_valid[waddr] <= 1'b1;
            end
        end
        if (i_cmd.in_load) begin
            r_sat  <= i_sat_index;
            r_sys  <= i_constellation;
            r_r1   <= i_range_first;
            r_r2   <= i_range_second;
            r_p1   <= i_phase_first;
            r_p2   <= i_phase_second;
            r_ee   <= i_epoch_end;
            r_vbit <= r_valid[raddr];
        end
        r_p_hi <= i_cmd.hi;
        r_prod <= prod;
        r_acc  <= n_acc;
        case (r_p_cap)
            CAP_D1:  r_d1 <= $signed(acc_r16[16 +: WIDE_W]);
            CAP_D2:  r_d2 <= $signed(acc_r16[16 +: WIDE_W]);
            CAP_M1:  r_m1 <= sat32($signed(acc_r32[ACC_W-1:32]));
            CAP_M2:  r_m2 <= sat32($signed(acc_r32[ACC_W-1:32]));
            default: begin
            end
        endcase
        if (div_done) begin
            if (i_cmd.div_sel) begin
                r_run2 <= run_new;
            end else begin
                r_run1 <= run_new;
            end
        end
        if (i_cmd.out_load) begin
            o_accepted       <= !skip;
            o_combo_first    <= skip ? '0 : r_m1;
            o_combo_second   <= skip ? '0 : r_m2;
            o_running_first  <= skip ? '0 : run1_v;
            o_running_second <= skip ? '0 : run2_v;
            o_epoch_done     <= r_ee;
        end
    end

    assign o_stat.skip     = skip;
    assign o_stat.first    = (n_cnt == '0);
    assign o_stat.div_done = div_done;
endmodule
